>>> design/pcnd_pkg.sv
// ----------------------------------------------------------------------------
// pcnd_pkg
// Shared types and constants of the prefix-code nibble decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcnd_pkg;

    // Bit buffer geometry
    localparam int unsigned BUF_BITS  = 16;
    localparam int unsigned FREE_W    = 5;
    localparam logic [FREE_W-1:0] FREE_RESET = 5'd16;
    localparam logic [FREE_W-1:0] FREE_LOW   = 5'd8;

    // Longest code the table may hold
    localparam logic [3:0] CODE_MAX = 4'd8;

    // Results one input word can cause at most
    localparam logic [2:0] MAX_RESULTS = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN = 3'd4;

    localparam logic [7:0] OUT_LEN_RESET = 8'd10;

    // One table entry, packed as in the configuration word
    typedef struct packed {
        logic [7:0] code;
        logic [3:0] sym;
        logic [3:0] len;
    } t_entry;

    // Result of the table search
    typedef struct packed {
        logic       hit;
        logic [3:0] len;
        logic [3:0] sym;
    } t_match;

    // Bit buffer commands
    typedef enum logic [1:0] {
        BUF_HOLD,
        BUF_LOAD,
        BUF_SHIFT
    } t_buf_op;

endpackage

`default_nettype wire

>>> design/pcnd_if.sv
// ----------------------------------------------------------------------------
// pcnd_if
// Handshake channels of the decoder: compressed input words, decoded result
// words and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcnd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface pcnd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       final_byte;
    logic       no_match_error;
    logic       run_end;

    modport source (output valid, output out_byte, output final_byte,
                    output no_match_error, output run_end, input ready);
    modport sink   (input valid, input out_byte, input final_byte,
                    input no_match_error, input run_end, output ready);
endinterface

interface pcnd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/pcnd_table.sv
// ----------------------------------------------------------------------------
// pcnd_table
// Code table and output length registers, and the priority search that
// finds the lowest-numbered entry matching the head of the bit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module pcnd_table
    import pcnd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pcnd_cfg_if.sink        i_cfg,
    input  wire logic [7:0] i_top,
    output t_match          o_match,
    output logic [7:0]      o_limit
);

    t_entry [3:0][3:0] r_table;
    logic   [7:0]      r_out_len;

    // Entry matches when enabled, code fits its length and leads the buffer
    function automatic logic entry_hit(t_entry e, logic [7:0] top);
        logic [8:0] mask;
        logic [7:0] lead;
        mask = 9'h1FF << e.len;
        lead = top >> (4'd8 - e.len);
        return (e.len != 4'd0) && (e.len <= CODE_MAX) &&
               ((e.code & mask[7:0]) == 8'd0) && (lead == e.code);
    endfunction

    // Configuration writes, always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table   <= '0;
            r_out_len <= OUT_LEN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TABLE_0: r_table[0] <= i_cfg.data;
                REG_TABLE_1: r_table[1] <= i_cfg.data;
                REG_TABLE_2: r_table[2] <= i_cfg.data;
                REG_TABLE_3: r_table[3] <= i_cfg.data;
                REG_OUT_LEN: r_out_len  <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // A length of zero behaves as one
    assign o_limit = (r_out_len == 8'd0) ? 8'd1 : r_out_len;

    // Priority search: walk down so the lowest hit is left standing
    always_comb begin
        t_entry w_e;
        o_match = '0;
        for (int q = TABLE_ENTRIES - 1; q >= 0; q--) begin
            w_e = r_table[q[3:2]][q[1:0]];
            if (entry_hit(w_e, i_top)) begin
                o_match.hit = 1'b1;
                o_match.len = w_e.len;
                o_match.sym = w_e.sym;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/pcnd_bitbuf.sv
// ----------------------------------------------------------------------------
// pcnd_bitbuf
// 16-bit bit buffer with free-bit count. Input words are merged in below the
// bits already held; codes leave it one bit per cycle from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pcnd_bitbuf
    import pcnd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_buf_op           i_op,
    input  wire logic [7:0]        i_byte,
    output logic [7:0]             o_top,
    output logic [FREE_W-1:0]      o_free
);

    logic [BUF_BITS-1:0] r_buf;
    logic [FREE_W-1:0]   r_free;
    logic [FREE_W-1:0]   w_sub;
    logic                w_room;

    // Word lands just below the held bits
    assign w_sub  = r_free - FREE_LOW;
    assign w_room = (r_free >= FREE_LOW) && (r_free <= FREE_RESET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_free <= FREE_RESET;
        end else begin
            case (i_op)
                BUF_LOAD: begin
                    if (w_room) begin
                        r_buf  <= r_buf | (BUF_BITS'(i_byte) << w_sub[3:0]);
                        r_free <= w_sub;
                    end
                end
                BUF_SHIFT: begin
                    r_buf  <= {r_buf[BUF_BITS-2:0], 1'b0};
                    r_free <= r_free + 5'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_top  = r_buf[BUF_BITS-1:BUF_BITS-8];
    assign o_free = r_free;

endmodule

`default_nettype wire

>>> design/prefix_code_nibble_decoder.sv
// ----------------------------------------------------------------------------
// prefix_code_nibble_decoder
// Table-driven prefix-code decoder: compressed words in, 4-bit symbols packed
// two to a word out, with a sticky no-match error and a stop after a set
// number of output words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       handshake
//  i_in      in   in_byte[7:0]                                  valid/ready
//  o_out     out  out_byte[7:0] final_byte no_match_error       valid/ready
//                 run_end
//  i_cfg     in   index[2:0] data[63:0]                         valid/ready
//
//  One input word is taken per run: a load, then for each code the search,
//  which shares the first shift, and one shift per bit of the code; then a
//  check that the buffer is down to 8 bits and the hand-over of the last
//  result. The bit buffer shifts one bit a cycle while a code is consumed.
//  A run that ends in the final word or in a no-match skips the check. A
//  sticky error run passes through S_FLUSH; a finished run stays in S_IDLE.
//  Reset is synchronous, active low; i_cfg never stalls. A stalled o_out
//  holds the decoder when a result is due while both the output and the
//  pending word registers are full, and holds the hand-over of the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_code_nibble_decoder
    import pcnd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pcnd_in_if.sink   i_in,
    pcnd_out_if.source o_out,
    pcnd_cfg_if.sink  i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_FLUSH
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_cnt, n_cnt;
    logic [3:0]          r_held, n_held;
    logic                r_await, n_await;
    logic [7:0]          r_bw, n_bw;
    logic                r_fin, n_fin;
    logic                r_err, n_err;
    logic [2:0]          r_nres, n_nres;
    logic                r_pend_v, n_pend_v;
    logic [7:0]          r_pend_byte, n_pend_byte;
    logic                r_pend_last, n_pend_last;
    logic                r_pend_err, n_pend_err;
    logic                r_out_v, n_out_v;
    logic [7:0]          r_out_byte, n_out_byte;
    logic                r_out_last, n_out_last;
    logic                r_out_err, n_out_err;
    logic                r_out_end, n_out_end;

    t_buf_op             w_op;
    t_match              w_match;
    logic [7:0]          w_top;
    logic [7:0]          w_limit;
    logic [FREE_W-1:0]   w_free;
    logic [7:0]          w_bw_inc;
    logic                w_out_free;
    logic                w_slot_ok;
    logic                w_loop;

    // Code table and search
    pcnd_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_top   (w_top),
        .o_match (w_match),
        .o_limit (w_limit)
    );

    // Bit buffer
    pcnd_bitbuf u_bitbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_byte  (i_in.in_byte),
        .o_top   (w_top),
        .o_free  (w_free)
    );

    assign i_in.ready = (r_state == S_IDLE);

    assign w_out_free = !r_out_v || o_out.ready;
    // A new result may be made once the pending one can move out
    assign w_slot_ok  = !r_pend_v || w_out_free;
    assign w_loop     = (w_free < FREE_LOW) && (r_nres < MAX_RESULTS) && !r_fin;
    assign w_bw_inc   = r_bw + 8'd1;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_held      = r_held;
        n_await     = r_await;
        n_bw        = r_bw;
        n_fin       = r_fin;
        n_err       = r_err;
        n_nres      = r_nres;
        n_pend_v    = r_pend_v;
        n_pend_byte = r_pend_byte;
        n_pend_last = r_pend_last;
        n_pend_err  = r_pend_err;
        n_out_v     = r_out_v;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        n_out_end   = r_out_end;
        w_op        = BUF_HOLD;

        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_nres = 3'd0;
                    if (r_fin) begin
                        n_state = S_IDLE;
                    end else if (r_err) begin
                        n_pend_v    = 1'b1;
                        n_pend_byte = 8'd0;
                        n_pend_last = 1'b0;
                        n_pend_err  = 1'b1;
                        n_state     = S_FLUSH;
                    end else begin
                        w_op    = BUF_LOAD;
                        n_state = S_DECODE;
                    end
                end
            end

            S_DECODE: begin
                if (!w_loop) begin
                    n_state = S_FLUSH;
                end else if (!w_match.hit) begin
                    // No entry fits: error word ends the run
                    if (w_slot_ok) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_byte = r_pend_byte;
                            n_out_last = r_pend_last;
                            n_out_err  = r_pend_err;
                            n_out_end  = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_byte = 8'd0;
                        n_pend_last = 1'b0;
                        n_pend_err  = 1'b1;
                        n_err       = 1'b1;
                        n_nres      = r_nres + 3'd1;
                        n_state     = S_FLUSH;
                    end
                end else if (r_await) begin
                    // High nibble: hold it and start consuming the code
                    n_held  = w_match.sym;
                    n_await = 1'b0;
                    w_op    = BUF_SHIFT;
                    n_cnt   = w_match.len[2:0] - 3'd1;
                    n_state = (w_match.len == 4'd1) ? S_DECODE : S_SHIFT;
                end else if (w_slot_ok) begin
                    // Low nibble completes a word
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out_byte = r_pend_byte;
                        n_out_last = r_pend_last;
                        n_out_err  = r_pend_err;
                        n_out_end  = 1'b0;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_byte = {r_held, w_match.sym};
                    n_pend_last = (w_bw_inc >= w_limit);
                    n_pend_err  = 1'b0;
                    n_bw        = w_bw_inc;
                    n_await     = 1'b1;
                    n_nres      = r_nres + 3'd1;
                    if (w_bw_inc >= w_limit) begin
                        n_fin   = 1'b1;
                        n_state = S_FLUSH;
                    end else begin
                        w_op    = BUF_SHIFT;
                        n_cnt   = w_match.len[2:0] - 3'd1;
                        n_state = (w_match.len == 4'd1) ? S_DECODE : S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                w_op  = BUF_SHIFT;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    n_state = S_DECODE;
                end
            end

            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out_byte = r_pend_byte;
                    n_out_last = r_pend_last;
                    n_out_err  = r_pend_err;
                    n_out_end  = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 3'd0;
            r_held   <= 4'd0;
            r_await  <= 1'b1;
            r_bw     <= 8'd0;
            r_fin    <= 1'b0;
            r_err    <= 1'b0;
            r_nres   <= 3'd0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_held   <= n_held;
            r_await  <= n_await;
            r_bw     <= n_bw;
            r_fin    <= n_fin;
            r_err    <= n_err;
            r_nres   <= n_nres;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_pend_byte <= n_pend_byte;
        r_pend_last <= n_pend_last;
        r_pend_err  <= n_pend_err;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
        r_out_end   <= n_out_end;
    end

    assign o_out.valid          = r_out_v;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.final_byte     = r_out_last;
    assign o_out.no_match_error = r_out_err;
    assign o_out.run_end        = r_out_end;

endmodule

`default_nettype wire

>>> bench/pcnd_decode_checker.sv
// ----------------------------------------------------------------------------
// pcnd_decode_checker
// Watches the input, result and configuration channels of the prefix-code
// nibble decoder. It keeps its own copy of the table, bit buffer and nibble
// packing state, works out the result words that each accepted input word
// must cause, and compares every result word with the oldest expected one.
// ----------------------------------------------------------------------------
module pcnd_decode_checker
    import pcnd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pcnd_in_if   i_in_mon,
    pcnd_out_if  i_out_mon,
    pcnd_cfg_if  i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       final_byte;
        logic       no_match_error;
        logic       run_end;
    } t_result;

    // Shadow configuration
    logic [63:0] table_q [4];
    logic [7:0]  out_len;

    // Shadow decoder state
    logic [15:0]       bitbuf;
    logic [FREE_W-1:0] free_cnt;
    logic [3:0]        high_nib;
    logic              want_high;
    logic [7:0]        words_out;
    logic              done;
    logic              err_sticky;

    t_result expected_words [$];

    function automatic t_entry table_entry(input int idx);
        return t_entry'(table_q[idx / 4][(idx % 4) * 16 +: 16]);
    endfunction

    // Lowest-numbered live entry whose code sits at the top of the buffer
    function automatic int first_hit();
        t_entry ent;
        int     hit;
        hit = -1;
        for (int i = 15; i >= 0; i--) begin
            if (i < TABLE_ENTRIES) begin
                ent = table_entry(i);
                if (ent.len != 4'd0 && ent.len <= CODE_MAX &&
                    (ent.code >> ent.len) == 8'd0 &&
                    (bitbuf >> (16 - ent.len)) == 16'(ent.code)) begin
                    hit = i;
                end
            end
        end
        return hit;
    endfunction

    function automatic t_result make_result(input logic [7:0] b, input logic fin,
                                            input logic err);
        t_result r;
        r.out_byte       = b;
        r.final_byte     = fin;
        r.no_match_error = err;
        r.run_end        = 1'b0;
        return r;
    endfunction

    // Load one compressed word and decode until at most 8 bits remain, MAX_RESULTS results are made or the run stops
    task automatic decode_in_word(input logic [7:0] din);
        t_result    found [4];
        t_result    r;
        t_entry     ent;
        int         hit;
        int         n;
        logic       stop;
        logic [7:0] lim;
        lim  = (out_len == 8'd0) ? 8'd1 : out_len;
        n    = 0;
        stop = 1'b0;
        if (done) begin
            return;
        end
        if (err_sticky) begin
            r = make_result(8'h00, 1'b0, 1'b1);
            r.run_end = 1'b1;
            expected_words.push_back(r);
            return;
        end
        if (free_cnt >= FREE_LOW) begin
            bitbuf   = bitbuf | (16'(din) << (free_cnt - FREE_LOW));
            free_cnt = free_cnt - FREE_LOW;
        end
        while (!stop && free_cnt < FREE_LOW && n < int'(MAX_RESULTS)) begin
            hit = first_hit();
            if (hit < 0) begin
                err_sticky = 1'b1;
                found[n]   = make_result(8'h00, 1'b0, 1'b1);
                n++;
                stop = 1'b1;
            end else begin
                ent      = table_entry(hit);
                bitbuf   = bitbuf << ent.len;
                free_cnt = free_cnt + FREE_W'(ent.len);
                if (want_high) begin
                    high_nib  = ent.sym;
                    want_high = 1'b0;
                end else begin
                    want_high = 1'b1;
                    words_out = words_out + 8'd1;
                    found[n]  = make_result({high_nib, ent.sym}, words_out >= lim, 1'b0);
                    n++;
                    if (words_out >= lim) begin
                        done = 1'b1;
                        stop = 1'b1;
                    end
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            r = found[k];
            r.run_end = (k == n - 1);
            expected_words.push_back(r);
        end
    endtask

    task automatic check_word();
        t_result want;
        if (expected_words.size() == 0) begin
            $error("result word with nothing expected: out_byte %0h", i_out_mon.out_byte);
            o_fail_count++;
        end else begin
            want = expected_words.pop_front();
            if (i_out_mon.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, i_out_mon.out_byte);
                o_fail_count++;
            end
            if (i_out_mon.final_byte !== want.final_byte) begin
                $error("final_byte: expected %0b, got %0b",
                       want.final_byte, i_out_mon.final_byte);
                o_fail_count++;
            end
            if (i_out_mon.no_match_error !== want.no_match_error) begin
                $error("no_match_error: expected %0b, got %0b",
                       want.no_match_error, i_out_mon.no_match_error);
                o_fail_count++;
            end
            if (i_out_mon.run_end !== want.run_end) begin
                $error("run_end: expected %0b, got %0b", want.run_end, i_out_mon.run_end);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Everything is sampled on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                table_q[k] = '0;
            end
            out_len    = OUT_LEN_RESET;
            bitbuf     = '0;
            free_cnt   = FREE_RESET;
            high_nib   = '0;
            want_high  = 1'b1;
            words_out  = '0;
            done       = 1'b0;
            err_sticky = 1'b0;
            expected_words.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                check_word();
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    REG_TABLE_0: table_q[0] = i_cfg_mon.data;
                    REG_TABLE_1: table_q[1] = i_cfg_mon.data;
                    REG_TABLE_2: table_q[2] = i_cfg_mon.data;
                    REG_TABLE_3: table_q[3] = i_cfg_mon.data;
                    REG_OUT_LEN: out_len    = i_cfg_mon.data[7:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_in_word(i_in_mon.in_byte);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> bench/tb_prefix_code_nibble_decoder.sv
// ----------------------------------------------------------------------------
// tb_prefix_code_nibble_decoder
// Stimulus and verdict for the prefix-code nibble decoder. Directed tables
// cover one-bit and eight-bit codes, disabled and shadowed entries; random
// prefix-code tables follow under several idling patterns and one long
// result stall. The run ends either in the final output word or in the
// sticky no-match error, chosen at random.
// ----------------------------------------------------------------------------
module tb_prefix_code_nibble_decoder;
    import pcnd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 30;
    localparam int PHASE_WORDS    = 20;

    logic i_clk;
    logic i_rst_n;

    pcnd_in_if  in_ch ();
    pcnd_out_if out_ch ();
    pcnd_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int send_gap_pct;
    int recv_stall_pct;
    int quiet_cycles;
    logic hold_req;

    logic [15:0] code_table [16];

    prefix_code_nibble_decoder #(
        .TABLE_ENTRIES (16)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pcnd_decode_checker #(
        .TABLE_ENTRIES (16)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [15:0] pack_entry(input logic [3:0] len, input logic [3:0] sym,
                                               input logic [7:0] code);
        t_entry ent;
        ent.len  = len;
        ent.sym  = sym;
        ent.code = code;
        return ent;
    endfunction

    // Called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_table();
        write_reg(REG_TABLE_0, {code_table[3], code_table[2], code_table[1], code_table[0]});
        write_reg(REG_TABLE_1, {code_table[7], code_table[6], code_table[5], code_table[4]});
        write_reg(REG_TABLE_2, {code_table[11], code_table[10], code_table[9], code_table[8]});
        write_reg(REG_TABLE_3, {code_table[15], code_table[14], code_table[13], code_table[12]});
    endtask

    // Stop offering, let every expected word out, then let a word that
    // produces no result finish inside the block
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random complete prefix code, padded with dead and shadowed entries
    task automatic random_table();
        logic [7:0] leaf_code [16];
        int         leaf_len [16];
        int         slot [16];
        int         nleaf;
        int         target;
        int         a;
        int         c;
        int         t;
        int         len;
        nleaf = 1;
        leaf_code[0] = 8'd0;
        leaf_len[0]  = 0;
        target = $urandom_range(6, 16);
        // Split the deeper of two random leaves to keep codes long on average
        while (nleaf < target) begin
            a = $urandom_range(nleaf - 1);
            c = $urandom_range(nleaf - 1);
            if (leaf_len[c] < 8 && (leaf_len[a] >= 8 || leaf_len[c] > leaf_len[a])) begin
                a = c;
            end
            if (leaf_len[a] < 8) begin
                leaf_code[nleaf] = (leaf_code[a] << 1) | 8'd1;
                leaf_len[nleaf]  = leaf_len[a] + 1;
                leaf_code[a]     = leaf_code[a] << 1;
                leaf_len[a]      = leaf_len[a] + 1;
                nleaf++;
            end
        end
        for (int i = 0; i < 16; i++) begin
            slot[i] = i;
        end
        for (int i = 15; i > 0; i--) begin
            a = $urandom_range(i);
            t = slot[i];
            slot[i] = slot[a];
            slot[a] = t;
        end
        for (int i = 0; i < 16; i++) begin
            if (i < nleaf) begin
                code_table[slot[i]] = pack_entry(4'(leaf_len[i]), 4'($urandom_range(15)),
                                                 leaf_code[i]);
            end else begin
                case ($urandom_range(3))
                    0: code_table[slot[i]] = pack_entry(4'd0, 4'($urandom_range(15)),
                                                        8'($urandom_range(255)));
                    1: code_table[slot[i]] = pack_entry(4'($urandom_range(9, 15)),
                                                        4'($urandom_range(15)),
                                                        8'($urandom_range(255)));
                    // Code too wide for its length
                    2: begin
                        len = $urandom_range(1, 7);
                        code_table[slot[i]] = pack_entry(4'(len), 4'($urandom_range(15)),
                                                         8'($urandom_range(255)) |
                                                         (8'd1 << len));
                    end
                    // Same code as a live leaf: whichever is lower wins
                    default: begin
                        a = $urandom_range(nleaf - 1);
                        code_table[slot[i]] = pack_entry(4'(leaf_len[a]),
                                                         4'($urandom_range(15)),
                                                         leaf_code[a]);
                    end
                endcase
            end
        end
    endtask

    initial begin
        logic [7:0] dir_words [10];
        int         finish_ending;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        hold_req       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(REG_OUT_LEN, 64'd255);

        // One-bit codes: eight symbols per word, four results per run
        for (int i = 0; i < 16; i++) begin
            code_table[i] = '0;
        end
        code_table[0] = pack_entry(4'd1, 4'h0, 8'h00);
        code_table[1] = pack_entry(4'd1, 4'hF, 8'h01);
        load_table();
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'hA5);
        send_word(8'h5A);
        send_word(8'h0F);
        wait_drained();

        // Lengths one to eight, dead entries and shadowed duplicates
        code_table[0]  = pack_entry(4'd0, 4'h1, 8'hFF);
        code_table[1]  = pack_entry(4'd9, 4'h2, 8'h00);
        code_table[2]  = pack_entry(4'd3, 4'h3, 8'h0C);
        code_table[3]  = pack_entry(4'd8, 4'hE, 8'hFF);
        code_table[4]  = pack_entry(4'd8, 4'h1, 8'hFF);
        code_table[5]  = pack_entry(4'd1, 4'h7, 8'h00);
        code_table[6]  = pack_entry(4'd2, 4'h9, 8'h02);
        code_table[7]  = pack_entry(4'd3, 4'hA, 8'h06);
        code_table[8]  = pack_entry(4'd4, 4'hB, 8'h0E);
        code_table[9]  = pack_entry(4'd5, 4'hC, 8'h1E);
        code_table[10] = pack_entry(4'd6, 4'hD, 8'h3E);
        code_table[11] = pack_entry(4'd7, 4'h6, 8'h7E);
        code_table[12] = pack_entry(4'd8, 4'h5, 8'hFE);
        code_table[13] = pack_entry(4'd15, 4'hF, 8'hAB);
        code_table[14] = pack_entry(4'd4, 4'h4, 8'h0E);
        code_table[15] = pack_entry(4'd2, 4'h2, 8'h00);
        load_table();
        dir_words = '{8'hFF, 8'hFF, 8'hFE, 8'h7F, 8'hBD, 8'h00, 8'h80, 8'h3C, 8'hF0, 8'h01};
        foreach (dir_words[i]) begin
            send_word(dir_words[i]);
        end
        wait_drained();

        // Random tables under each idling pattern, twice over
        for (int ph = 0; ph < 8; ph++) begin
            random_table();
            load_table();
            if (ph == 4) begin
                write_reg(REG_OUT_LEN, 64'($urandom_range(250, 254)));
            end
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 72; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 72; end
                default: begin send_gap_pct = 22; recv_stall_pct = 22; end
            endcase
            // Long result stall while words keep coming in
            if (ph == 4) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_WORDS) send_word(8'($urandom_range(255)));
            wait_drained();
        end

        // Either run to the final word, or break the code and go sticky
        send_gap_pct   = 22;
        recv_stall_pct = 22;
        finish_ending  = $urandom_range(1);
        if (finish_ending != 0) begin
            write_reg(REG_OUT_LEN, 64'd1);
        end else begin
            for (int i = 0; i < 16; i++) begin
                code_table[i] = '0;
            end
            code_table[0] = pack_entry(4'd2, 4'h5, 8'h00);
            load_table();
            send_word(8'h00);
            send_word(8'h0C);
        end
        repeat (12) send_word(8'($urandom_range(255)));
        wait_drained();

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
